// ===== rtl/piq_pkg.sv =====
// Shared types and constants for the pending interrupt queue.
// Holds the item structs and the command and status structs between controller and datapath.
// Has no dependencies of its own.
`default_nettype none

package piq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths.
    localparam int CODE_W  = 4;
    localparam int MASK_W  = 16;
    localparam int PEND_W  = 5;

    // Function codes of an input item.
    localparam logic FUNC_RAISE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // One input item.
    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
        logic              interrupts_enabled;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] fetched_code;
        logic              dropped;
        logic [PEND_W-1:0] pending_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // Capture the input item, clear found and the fetched code, load the drop flag.
        logic raise_push;  // Append the input code at the newest end.
        logic raise_drop;  // Flag the raise as dropped.
        logic idx_newest;  // Point the index at the newest entry.
        logic idx_first;   // Point the index at the oldest entry.
        logic idx_next;    // Advance the index by one.
        logic take;        // Record the code just read as the fetched code.
        logic move;        // Copy the code just read one place down.
        logic count_dec;   // Remove one entry from the count.
        logic load_out;    // Load the output register.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_fetch;    // The offered input item is a fetch.
        logic in_enabled;  // The offered input item has interrupts enabled.
        logic full;        // The queue holds QUEUE_DEPTH codes.
        logic empty;       // The queue holds no code.
        logic enabled;     // The captured item has interrupts enabled.
        logic unmasked;    // The code just read is not maskable.
        logic last;        // The index points at the newest entry.
        logic out_free;    // The output register can take a result.
    } t_status;

endpackage : piq_pkg

`default_nettype wire

// ===== rtl/piq_datapath.sv =====
// Datapath of the pending interrupt queue: code store, count, scan index and output register.
// Driven by piq_ctrl through the command struct; uses types from piq_pkg.
`default_nettype none

module piq_datapath
    import piq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_in_item          i_in_item,
    input  wire logic [MASK_W-1:0] i_maskable,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item
);

    // Code store, oldest entry at address zero.
    logic [CODE_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [CODE_W-1:0]  r_rd_data;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] r_idx;
    logic [COUNT_W-1:0] n_idx;
    logic               r_enabled;
    logic               r_found;
    logic [CODE_W-1:0]  r_fcode;
    logic               r_dropped;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [CODE_W-1:0]  wr_data;
    logic [COUNT_W-1:0] idx_plus;
    logic [COUNT_W-1:0] idx_minus;

    assign idx_plus  = r_idx + COUNT_W'(1);
    assign idx_minus = r_idx - COUNT_W'(1);

    // A write comes either from a raise or from one step of compaction.
    always_comb begin
        wr_en   = i_cmd.raise_push | i_cmd.move;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = i_in_item.code;
        if (i_cmd.move) begin
            wr_addr = idx_minus[IDX_W-1:0];
            wr_data = r_rd_data;
        end
    end

    // Store with one write port and one registered read port at the scan index.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
    end

    // Next count and next index.
    always_comb begin
        n_count = r_count;
        if (i_cmd.raise_push) begin
            n_count = r_count + COUNT_W'(1);
        end else if (i_cmd.count_dec) begin
            n_count = r_count - COUNT_W'(1);
        end

        n_idx = r_idx;
        if (i_cmd.idx_newest) begin
            n_idx = r_count - COUNT_W'(1);
        end else if (i_cmd.idx_first) begin
            n_idx = '0;
        end else if (i_cmd.idx_next) begin
            n_idx = idx_plus;
        end
    end

    // The output register empties when its item is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Item and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_enabled <= i_in_item.interrupts_enabled;
            r_found   <= 1'b0;
            r_fcode   <= '0;
            r_dropped <= i_cmd.raise_drop;
        end else if (i_cmd.take) begin
            r_found <= 1'b1;
            r_fcode <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_out.found         <= r_found;
            r_out.fetched_code  <= r_fcode;
            r_out.dropped       <= r_dropped;
            r_out.pending_count <= PEND_W'(r_count);
        end
    end

    // Status back to the controller.
    always_comb begin
        o_status.in_fetch   = (i_in_item.func == FUNC_FETCH);
        o_status.in_enabled = i_in_item.interrupts_enabled;
        o_status.full       = (r_count == COUNT_W'(QUEUE_DEPTH));
        o_status.empty      = (r_count == '0);
        o_status.enabled    = r_enabled;
        o_status.unmasked   = !i_maskable[r_rd_data];
        o_status.last       = (idx_plus >= r_count);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule : piq_datapath

`default_nettype wire

// ===== rtl/piq_ctrl.sv =====
// Controller of the pending interrupt queue: sequences raise, pop, scan and compaction.
// Talks to piq_datapath through the command and status structs of piq_pkg.
`default_nettype none

module piq_ctrl
    import piq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_READ    = 6'b000010,
        S_CHECK   = 6'b000100,
        S_MOVE_RD = 6'b001000,
        S_MOVE_WR = 6'b010000,
        S_FINISH  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    if (!i_status.in_fetch) begin
                        // A raise finishes at once, dropped when the queue is full.
                        o_cmd.raise_push = !i_status.full;
                        o_cmd.raise_drop = i_status.full;
                        n_state          = S_FINISH;
                    end else if (i_status.empty) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.idx_newest = i_status.in_enabled;
                        o_cmd.idx_first  = !i_status.in_enabled;
                        n_state          = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.enabled) begin
                    // Enabled fetch pops the newest code.
                    o_cmd.take      = 1'b1;
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_status.unmasked) begin
                    // Found the oldest unmasked code; close the gap behind it.
                    o_cmd.take = 1'b1;
                    if (i_status.last) begin
                        o_cmd.count_dec = 1'b1;
                        n_state         = S_FINISH;
                    end else begin
                        o_cmd.idx_next = 1'b1;
                        n_state        = S_MOVE_RD;
                    end
                end else if (i_status.last) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.idx_next = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_MOVE_RD: begin
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_cmd.move = 1'b1;
                if (i_status.last) begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.idx_next = 1'b1;
                    n_state        = S_MOVE_RD;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule : piq_ctrl

`default_nettype wire

// ===== rtl/pending_interrupt_queue.sv =====
// Top level of the pending interrupt queue: mask register, controller and datapath.
// Instantiates piq_ctrl and piq_datapath; uses types from piq_pkg.
//
// Queue of up to QUEUE_DEPTH 4-bit interrupt codes kept in arrival order. A raise
// item appends its code, or flags dropped if the queue is full. A fetch item with
// interrupts enabled pops the newest code; with them disabled it removes the oldest
// code whose bit in the maskable register is clear and shifts the newer codes down,
// returning found = 0 if every code is maskable. Each item gives exactly one result
// holding the queue count after the item. Items are handled one at a time; the
// codes sit in a store with one write port and a registered read, so every scanned
// entry passes through a read and a check state, and every moved entry through
// a move-read and a move-write state. Scanned and moved entries together never
// exceed the queue count. A finished result waits in the output register while
// the next item is taken. The code store needs no clearing after reset. The
// maskable register may be written at any time the block is idle; its port is
// always ready.
`default_nettype none

module pending_interrupt_queue
    import piq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [MASK_W-1:0] i_cfg_data
);

    logic [MASK_W-1:0] r_maskable;
    t_cmd              w_cmd;
    t_status           w_status;

    // Maskable code register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maskable <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_maskable <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    piq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    piq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_maskable  (r_maskable),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // After an item is taken the block is busy until its result is stored.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    // A result without a found code carries a zero code.
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.fetched_code == '0))
        else $error("fetched code not zero when nothing was found");

    // A dropped raise reports a full queue.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.dropped)
            |-> (o_out_item.pending_count == PEND_W'(QUEUE_DEPTH)))
        else $error("dropped raise with a queue that is not full");

    // A result never both drops and finds a code.
    a_drop_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.dropped && o_out_item.found))
        else $error("result both dropped and found");
`endif

endmodule : pending_interrupt_queue

`default_nettype wire
